@@ hw/rtl/cfb_pkg.sv @@
`default_nettype none
package cfb_pkg;

  // Input item kinds carried on s_tuser
  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  // Configuration register indexes
  localparam logic CFG_START_MARKER = 1'b0;
  localparam logic CFG_END_MARKER   = 1'b1;

  localparam logic [7:0]  START_MARKER_RST = 8'hAA;
  localparam logic [7:0]  END_MARKER_RST   = 8'h00;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'hA001;
  localparam logic [7:0]  LEN_OVERHEAD     = 8'd3;

  typedef enum logic {
    JOB_START   = 1'b0,
    JOB_PAYLOAD = 1'b1
  } job_kind_t;

  // One classified request from the front to the back
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] data;   // command for a start, payload byte otherwise
    logic [7:0] len;    // length byte of a start
    logic       close;  // frame ends after this request
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_CMD,
    ST_CRC_LO,
    ST_CRC_HI,
    ST_END
  } back_state_t;

  // CRC-16/MODBUS update over one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/cfb_front.sv @@
`default_nettype none
module cfb_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [23:0]   s_tdata,
  input  wire logic          s_tuser,
  input  wire logic          q_full,
  output logic               q_push,
  output cfb_pkg::job_t      q_job
);
  import cfb_pkg::*;

  logic       frame_open;
  logic       frame_open_next;
  logic [7:0] bytes_left;
  logic [7:0] bytes_left_next;
  logic       accept;
  logic [7:0] command;
  logic [7:0] payload_count;
  logic [7:0] payload_byte;

  assign command       = s_tdata[7:0];
  assign payload_count = s_tdata[15:8];
  assign payload_byte  = s_tdata[23:16];

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // Classify the request, track the open frame, drop stray payload
  always_comb begin
    frame_open_next = frame_open;
    bytes_left_next = bytes_left;
    q_push          = 1'b0;
    q_job.kind      = JOB_START;
    q_job.data      = command;
    q_job.len       = payload_count + LEN_OVERHEAD;
    q_job.close     = (payload_count == 8'd0);
    if (accept) begin
      if (s_tuser == OP_START) begin
        q_push          = 1'b1;
        frame_open_next = (payload_count != 8'd0);
        bytes_left_next = payload_count;
      end else if (frame_open) begin
        q_push          = 1'b1;
        q_job.kind      = JOB_PAYLOAD;
        q_job.data      = payload_byte;
        q_job.close     = (bytes_left == 8'd1);
        bytes_left_next = bytes_left - 8'd1;
        frame_open_next = (bytes_left != 8'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      bytes_left <= 8'd0;
    end else begin
      frame_open <= frame_open_next;
      bytes_left <= bytes_left_next;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/cfb_queue.sv @@
`default_nettype none
module cfb_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire cfb_pkg::job_t  push_job,
  input  wire logic           pop,
  output cfb_pkg::job_t       head_job,
  output logic                empty,
  output logic                full
);
  import cfb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign empty    = (fill == CW'(0));
  assign full     = (fill == CW'(DEPTH));
  assign head_job = slots[rd_ptr];

  // Store pushed request
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/cfb_back.sv @@
`default_nettype none
module cfb_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic           cfg_index,
  input  wire logic [7:0]     cfg_data,
  input  wire cfb_pkg::job_t  head_job,
  input  wire logic           q_empty,
  output logic                q_pop,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic [7:0]          m_tdata,
  output logic                m_tlast
);
  import cfb_pkg::*;

  back_state_t state;
  back_state_t state_next;
  logic [7:0]  start_marker;
  logic [7:0]  end_marker;
  logic [15:0] crc;
  logic [15:0] crc_next;
  logic [7:0]  cmd;
  logic [7:0]  len;
  logic        close;
  logic        load;
  logic        emit;
  logic [7:0]  emit_byte;
  logic        emit_last;
  logic        latch_start;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RST;
      end_marker   <= END_MARKER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_MARKER: start_marker <= cfg_data;
        CFG_END_MARKER:   end_marker   <= cfg_data;
        default:          start_marker <= start_marker;
      endcase
    end
  end

  // Output register may take a new byte when empty or being drained
  assign load = !m_tvalid || m_tready;

  // Sequence the frame bytes and fold them into the CRC
  always_comb begin
    state_next  = state;
    crc_next    = crc;
    emit        = 1'b0;
    emit_byte   = 8'h00;
    emit_last   = 1'b0;
    q_pop       = 1'b0;
    latch_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (load && !q_empty) begin
          emit  = 1'b1;
          q_pop = 1'b1;
          if (head_job.kind == JOB_START) begin
            emit_byte   = start_marker;
            crc_next    = CRC_INIT;
            latch_start = 1'b1;
            state_next  = ST_LEN;
          end else begin
            emit_byte  = head_job.data;
            crc_next   = crc_byte(crc, head_job.data);
            state_next = head_job.close ? ST_CRC_LO : ST_IDLE;
          end
        end
      end
      ST_LEN: begin
        if (load) begin
          emit       = 1'b1;
          emit_byte  = len;
          crc_next   = crc_byte(crc, len);
          state_next = ST_CMD;
        end
      end
      ST_CMD: begin
        if (load) begin
          emit       = 1'b1;
          emit_byte  = cmd;
          crc_next   = crc_byte(crc, cmd);
          state_next = close ? ST_CRC_LO : ST_IDLE;
        end
      end
      ST_CRC_LO: begin
        if (load) begin
          emit       = 1'b1;
          emit_byte  = crc[7:0];
          state_next = ST_CRC_HI;
        end
      end
      ST_CRC_HI: begin
        if (load) begin
          emit       = 1'b1;
          emit_byte  = crc[15:8];
          state_next = ST_END;
        end
      end
      ST_END: begin
        if (load) begin
          emit       = 1'b1;
          emit_byte  = end_marker;
          emit_last  = 1'b1;
          crc_next   = CRC_INIT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold sequencer state and CRC
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      crc   <= CRC_INIT;
      close <= 1'b0;
    end else begin
      state <= state_next;
      crc   <= crc_next;
      if (latch_start) begin
        close <= head_job.close;
      end
    end
  end

  // Latch start fields
  always_ff @(posedge clk) begin
    if (latch_start) begin
      cmd <= head_job.data;
      len <= head_job.len;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (load && emit) begin
      m_tdata <= emit_byte;
      m_tlast <= emit_last;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/crc16_frame_builder_top.sv @@
// crc16_frame_builder_top: serial packet encoder with CRC-16/MODBUS.
//
// Input stream (s_*): s_tuser selects the request kind (0 start, 1 payload).
// A start request emits the start marker, length (count + 3) and command;
// each payload request inside an open frame emits its byte. After the last
// payload byte, or right after the command when the count is zero, the CRC
// (low byte first) and the end marker follow, the end marker with m_tlast.
// Payload outside a frame is dropped; a new start abandons an open frame.
// Output stream (m_*) carries one frame byte per transfer.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 start marker, 1 end marker); write only while the block is idle.
// An accepted request passes through the request queue, then the output
// register, before its first byte shows on m_tdata.
// The byte sequencer in the back end sends one output byte per cycle while
// m_tready is high; payload requests go at one per cycle, a start gives 3
// output bytes and a frame close 3 more.
// Reset (rst, synchronous): queue empties, no frame open, markers return to
// 0xAA and 0x00. When m_tready is low the output byte holds and the request
// queue (QUEUE_DEPTH entries) fills, then s_tready drops.
`default_nettype none
module crc16_frame_builder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // command[7:0], payload_count[15:8], payload_byte[23:16]
  input  wire logic        s_tuser,   // op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // out_byte[7:0]
  output logic             m_tlast,   // frame_end
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import cfb_pkg::*;

  job_t push_job;
  job_t head_job;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;

  cfb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (push),
    .q_job    (push_job)
  );

  cfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  cfb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head_job  (head_job),
    .q_empty   (q_empty),
    .q_pop     (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
`default_nettype wire

@@ hw/rtl/cfb_checker.sv @@
`default_nettype none
module cfb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata,
  input wire logic        m_tlast
);

  // Hold a stalled output byte
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  // Reset drains the output register
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Reset empties the request queue
  assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

endmodule

bind crc16_frame_builder_top cfb_checker u_cfb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire

@@ bench/crc16_frame_builder_top_tb.sv @@
`default_nettype none
module crc16_frame_builder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfb_pkg::*;

  localparam int RESET_CYCLES  = 12;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 20;
  localparam int HOLD_PAYLOAD  = 12;
  localparam int NUM_PHASES    = 4;
  localparam int REPORT_LIMIT  = 10;

  // Idle and stall odds per phase, in percent
  localparam int SEND_IDLE [NUM_PHASES] = '{0, 67, 0, 11};
  localparam int RECV_STALL[NUM_PHASES] = '{0, 0, 67, 11};

  // One byte on the wire
  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } wire_byte_t;

  // One directed request; typed rows carry their wire bytes (none ends a frame)
  typedef struct packed {
    logic       op;
    logic [7:0] cmd;
    logic [7:0] cnt;
    logic [7:0] pb;
    logic       typed;
    logic [1:0] n_typed;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } dir_row_t;

  localparam int DIR_ROWS = 18;
  localparam dir_row_t DIR_TABLE[DIR_ROWS] = '{
    // payload with no frame open right after reset
    '{OP_PAYLOAD, 8'h00, 8'h00, 8'hFF, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    // empty frame closes at once
    '{OP_START,   8'h00, 8'h00, 8'h00, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{OP_START,   8'hFF, 8'h02, 8'h00, 1'b1, 2'd3, 8'hAA, 8'h05, 8'hFF},
    '{OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 1'b1, 2'd1, 8'h00, 8'h00, 8'h00},
    '{OP_PAYLOAD, 8'hFF, 8'hFF, 8'hFF, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    // stray payload after a close
    '{OP_PAYLOAD, 8'h12, 8'h34, 8'h5A, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{OP_START,   8'h81, 8'h03, 8'h00, 1'b1, 2'd3, 8'hAA, 8'h06, 8'h81},
    '{OP_PAYLOAD, 8'h00, 8'h00, 8'h12, 1'b1, 2'd1, 8'h12, 8'h00, 8'h00},
    // new start abandons the open frame
    '{OP_START,   8'h42, 8'h01, 8'h00, 1'b1, 2'd3, 8'hAA, 8'h04, 8'h42},
    '{OP_PAYLOAD, 8'h00, 8'h00, 8'hC3, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    // largest legal count, then the counts whose length byte wraps
    '{OP_START,   8'h7E, 8'hFC, 8'h00, 1'b1, 2'd3, 8'hAA, 8'hFF, 8'h7E},
    '{OP_PAYLOAD, 8'h00, 8'h00, 8'hA5, 1'b1, 2'd1, 8'hA5, 8'h00, 8'h00},
    '{OP_START,   8'h01, 8'hFD, 8'h00, 1'b1, 2'd3, 8'hAA, 8'h00, 8'h01},
    '{OP_START,   8'h80, 8'hFF, 8'h00, 1'b1, 2'd3, 8'hAA, 8'h02, 8'h80},
    '{OP_START,   8'h3C, 8'hFE, 8'h00, 1'b1, 2'd3, 8'hAA, 8'h01, 8'h3C},
    '{OP_START,   8'h55, 8'h01, 8'h00, 1'b1, 2'd3, 8'hAA, 8'h04, 8'h55},
    '{OP_PAYLOAD, 8'hFF, 8'hFF, 8'hAA, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{OP_START,   8'hC0, 8'h00, 8'h00, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00}
  };

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata   = '0;   // command[7:0], payload_count[15:8], payload_byte[23:16]
  logic        s_tuser   = 1'b0; // op
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;          // out_byte[7:0]
  logic        m_tlast;          // frame_end
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data  = '0;

  // Frame predictor state
  logic [7:0]  mk_start  = START_MARKER_RST;
  logic [7:0]  mk_end    = END_MARKER_RST;
  logic        frame_busy = 1'b0;
  logic [7:0]  bytes_due  = '0;
  logic [15:0] crc_acc    = CRC_INIT;
  wire_byte_t  step_out[6];
  int          step_n;

  // Wire bytes still owed by the block, oldest first
  wire_byte_t  due_bytes_q[$];

  int          send_idle     = 0;
  int          stall_pct     = 0;
  int          hold_gen      = 0;
  int          hold_seen     = 0;
  int          hold_left     = 0;
  int          mismatch_count = 0;
  int unsigned cycle_count   = 0;

  crc16_frame_builder_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Shift one byte through the MODBUS CRC, bit 0 first
  function automatic logic [15:0] crc_mix(input logic [15:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic void emit(input logic [7:0] b, input logic last);
    step_out[step_n] = '{out_byte: b, frame_end: last};
    step_n++;
  endfunction

  // Append CRC low, CRC high and end marker; reset the frame
  function automatic void close_frame_out();
    emit(crc_acc[7:0], 1'b0);
    emit(crc_acc[15:8], 1'b0);
    emit(mk_end, 1'b1);
    frame_busy = 1'b0;
    bytes_due  = '0;
    crc_acc    = CRC_INIT;
  endfunction

  // Advance the predictor by one accepted request, filling step_out
  function automatic void build_step(input logic op, input logic [7:0] cmd,
                                     input logic [7:0] cnt, input logic [7:0] pb);
    logic [7:0] len;
    step_n = 0;
    if (op == OP_START) begin
      len = cnt + LEN_OVERHEAD;
      emit(mk_start, 1'b0);
      emit(len, 1'b0);
      emit(cmd, 1'b0);
      crc_acc    = crc_mix(crc_mix(CRC_INIT, len), cmd);
      bytes_due  = cnt;
      frame_busy = 1'b1;
      if (cnt == 8'd0) begin
        close_frame_out();
      end
    end else if (frame_busy) begin
      emit(pb, 1'b0);
      crc_acc   = crc_mix(crc_acc, pb);
      bytes_due = bytes_due - 8'd1;
      if (bytes_due == 8'd0) begin
        close_frame_out();
      end
    end
  endfunction

  // Offer one request, wait for acceptance, then predict its bytes
  task automatic send_req(input logic op, input logic [7:0] cmd, input logic [7:0] cnt,
                          input logic [7:0] pb, input logic typed);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {pb, cnt, cmd};
    do @(posedge clk); while (!s_tready);
    build_step(op, cmd, cnt, pb);
    if (!typed) begin
      for (int k = 0; k < step_n; k++) begin
        due_bytes_q.push_back(step_out[k]);
      end
    end
  endtask

  // Drop valid, wait out every owed byte, then let stray work settle
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (due_bytes_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both marker registers on consecutive edges
  task automatic set_markers(input logic [7:0] first_mk, input logic [7:0] last_mk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_MARKER;
    cfg_data  <= first_mk;
    @(posedge clk);
    mk_start  = first_mk;
    cfg_index <= CFG_END_MARKER;
    cfg_data  <= last_mk;
    @(posedge clk);
    mk_end    = last_mk;
    cfg_we    <= 1'b0;
  endtask

  // Mostly whole frames of small size; some abandoned, some stray payload
  task automatic random_traffic(input int quota);
    int sent;
    int cnt;
    int npay;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 9) == 0) begin
        send_req(OP_PAYLOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 1'b0);
        if (step_n != 0) sent++;
      end else begin
        cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 255) : $urandom_range(0, 6);
        npay = (cnt > 24) ? $urandom_range(0, 24) : cnt;
        if (cnt > 0 && $urandom_range(0, 4) == 0) begin
          npay = $urandom_range(0, (npay > 0) ? npay - 1 : 0);
        end
        send_req(OP_START, 8'($urandom_range(0, 255)), 8'(cnt),
                 8'($urandom_range(0, 255)), 1'b0);
        sent++;
        for (int k = 0; k < npay; k++) begin
          send_req(OP_PAYLOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 1'b0);
          sent++;
        end
      end
    end
  endtask

  // Stimulus
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests at reset markers
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_req(DIR_TABLE[r].op, DIR_TABLE[r].cmd, DIR_TABLE[r].cnt, DIR_TABLE[r].pb,
               DIR_TABLE[r].typed);
      if (DIR_TABLE[r].typed) begin
        if (DIR_TABLE[r].n_typed > 0) due_bytes_q.push_back('{DIR_TABLE[r].b0, 1'b0});
        if (DIR_TABLE[r].n_typed > 1) due_bytes_q.push_back('{DIR_TABLE[r].b1, 1'b0});
        if (DIR_TABLE[r].n_typed > 2) due_bytes_q.push_back('{DIR_TABLE[r].b2, 1'b0});
      end
    end
    wait_drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          set_markers(8'h00, 8'hFF);
        end
        1: begin
          set_markers(8'hFF, 8'h00);
        end
        2: begin
          set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        default: begin
          set_markers(8'h7E, 8'hAA);
        end
      endcase
      send_idle = SEND_IDLE[ph];
      stall_pct <= RECV_STALL[ph];

      // Hold the receiver off while a frame longer than the queue streams in
      if (ph == 0) begin
        hold_gen <= hold_gen + 1;
        send_req(OP_START, 8'($urandom_range(0, 255)), 8'(HOLD_PAYLOAD), 8'h00, 1'b0);
        for (int k = 0; k < HOLD_PAYLOAD; k++) begin
          send_req(OP_PAYLOAD, 8'h00, 8'h00, 8'($urandom_range(0, 255)), 1'b0);
        end
        wait_drain();
      end

      random_traffic(PHASE_ITEMS);
      wait_drain();
    end

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver: long hold-off on request, otherwise random stalls
  always @(posedge clk) begin
    if (hold_gen != hold_seen) begin
      hold_seen <= hold_gen;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Compare each output byte with the oldest owed byte
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (due_bytes_q.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < REPORT_LIMIT) begin
          $display("unexpected output: byte %02h last %0b", m_tdata, m_tlast);
        end
      end else begin
        if (due_bytes_q[0].out_byte !== m_tdata || due_bytes_q[0].frame_end !== m_tlast) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < REPORT_LIMIT) begin
            $display("output mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                     due_bytes_q[0].out_byte, due_bytes_q[0].frame_end, m_tdata, m_tlast);
          end
        end
        void'(due_bytes_q.pop_front());
      end
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
`default_nettype wire
